@@ rtl/pdsg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdsg_pkg: shared types and constants for the density splat grid
// Grid geometry, field widths, register map and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package pdsg_pkg;

    // grid geometry
    localparam int GRID_X     = 32;
    localparam int GRID_Y     = 32;
    localparam int GRID_Z     = 32;
    localparam int GRID_CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int ADDR_W     = $clog2(GRID_CELLS);

    // stamp geometry
    localparam int STAMP_MAX = 7;
    localparam int SW        = $clog2(STAMP_MAX + 1);
    localparam int DSQ_W     = 2 * SW + 8;

    // floor((pos - origin) * inv / 2^32) fits in this many signed bits
    localparam int CELL_W = 26;

    // axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // register map (word index)
    localparam int APB_AW = 5;
    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [2:0] REG_INV_CELL  = 3'd3;
    localparam logic [2:0] REG_STAMP_SZ  = 3'd4;
    localparam logic [2:0] REG_RADIUS_SQ = 3'd5;
    localparam logic [2:0] REG_WEIGHT    = 3'd6;

    // stream payload widths
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic [23:0]        inv_cell_len;
        logic [2:0]         stamp_size;
        logic [5:0]         stamp_radius_sq;
        logic [15:0]        stamp_weight;
    } cfg_t;

    typedef struct packed {
        logic       capture;
        logic       diff_en;
        logic [1:0] diff_axis;
        logic       pp_en;
        logic       cell_en;
        logic [1:0] cell_axis;
        logic       walk_clr;
        logic       walk_step;
        logic       clr_step;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic size_zero;
        logic walk_last;
        logic clr_last;
    } sts_t;

endpackage
`default_nettype wire

@@ rtl/pdsg_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdsg_cfg: configuration register file
// APB-style slave holding grid origin, cell scale, stamp shape and stamp weight.
// ----------------------------------------------------------------------------
module pdsg_cfg
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pdsg_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output pdsg_pkg::cfg_t                  cfg
);
    import pdsg_pkg::*;

    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_y_reg;
    logic signed [31:0] origin_z_reg;
    logic [23:0]        inv_cell_reg;
    logic [2:0]         stamp_size_reg;
    logic [5:0]         radius_sq_reg;
    logic [15:0]        weight_reg;

    logic       wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            origin_z_reg   <= '0;
            inv_cell_reg   <= 24'd65536;
            stamp_size_reg <= 3'd5;
            radius_sq_reg  <= 6'd4;
            weight_reg     <= 16'd6554;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_ORIGIN_X:  origin_x_reg   <= pwdata;
                REG_ORIGIN_Y:  origin_y_reg   <= pwdata;
                REG_ORIGIN_Z:  origin_z_reg   <= pwdata;
                REG_INV_CELL:  inv_cell_reg   <= pwdata[23:0];
                REG_STAMP_SZ:  stamp_size_reg <= pwdata[2:0];
                REG_RADIUS_SQ: radius_sq_reg  <= pwdata[5:0];
                REG_WEIGHT:    weight_reg     <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            REG_ORIGIN_X:  prdata = origin_x_reg;
            REG_ORIGIN_Y:  prdata = origin_y_reg;
            REG_ORIGIN_Z:  prdata = origin_z_reg;
            REG_INV_CELL:  prdata = {8'd0, inv_cell_reg};
            REG_STAMP_SZ:  prdata = {29'd0, stamp_size_reg};
            REG_RADIUS_SQ: prdata = {26'd0, radius_sq_reg};
            REG_WEIGHT:    prdata = {16'd0, weight_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.origin_x        = origin_x_reg;
    assign cfg.origin_y        = origin_y_reg;
    assign cfg.origin_z        = origin_z_reg;
    assign cfg.inv_cell_len    = inv_cell_reg;
    assign cfg.stamp_size      = stamp_size_reg;
    assign cfg.stamp_radius_sq = radius_sq_reg;
    assign cfg.stamp_weight    = weight_reg;

endmodule
`default_nettype wire

@@ rtl/pdsg_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdsg_dp: splat datapath
// Cell computation through a shared split multiplier, stamp walk counters,
// grid memory with read-modify-write stage, clear sweep and result register.
// ----------------------------------------------------------------------------
module pdsg_dp
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pdsg_pkg::cfg_t                cfg,
    input  wire pdsg_pkg::cmd_t                cmd,
    input  wire logic [pdsg_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    output pdsg_pkg::sts_t                     sts,
    output logic [pdsg_pkg::M_TDATA_W-1:0]     m_tdata
);
    import pdsg_pkg::*;

    // captured item
    logic               act_reg;
    logic signed [31:0] pos_reg [3];
    logic [4:0]         rcx_reg;
    logic [4:0]         rcy_reg;
    logic [4:0]         rcz_reg;

    // cell computation pipeline
    logic signed [32:0]       diff_reg;
    logic signed [41:0]       pp_hi_reg;
    logic [39:0]              pp_lo_reg;
    logic signed [CELL_W-1:0] cell_reg [3];

    // stamp walk
    logic [SW-1:0] gx_reg;
    logic [SW-1:0] gy_reg;
    logic [SW-1:0] gz_reg;
    logic          hit_reg;
    logic [ADDR_W-1:0] wa_reg;
    logic [8:0]    added_reg;
    logic          sat_reg;

    // grid memory
    logic [31:0]       mem [GRID_CELLS];
    logic [31:0]       rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              rd_ok_reg;

    // result
    logic [31:0] out_dens_reg;
    logic [8:0]  out_added_reg;
    logic        out_sat_reg;

    logic signed [31:0]       org_sel;
    logic signed [31:0]       pos_sel;
    logic signed [16:0]       diff_hi;
    logic signed [57:0]       prod;
    logic [SW-1:0]            size;
    logic [SW-1:0]            half;
    logic [SW-1:0]            last_g;
    logic signed [SW:0]       ox;
    logic signed [SW:0]       oy;
    logic signed [SW:0]       oz;
    logic signed [DSQ_W-1:0]  sx;
    logic signed [DSQ_W-1:0]  sy;
    logic signed [DSQ_W-1:0]  sz;
    logic [DSQ_W-1:0]         dsq;
    logic signed [CELL_W-1:0] tx;
    logic signed [CELL_W-1:0] ty;
    logic signed [CELL_W-1:0] tz;
    logic                     in_grid;
    logic                     hit;
    logic [ADDR_W-1:0]        walk_addr;
    logic [ADDR_W-1:0]        read_addr;
    logic                     read_ok;
    logic [ADDR_W-1:0]        ra;
    logic [32:0]              sum;
    logic [31:0]              sat_sum;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg    <= s_tuser;
            pos_reg[0] <= s_tdata[31:0];
            pos_reg[1] <= s_tdata[63:32];
            pos_reg[2] <= s_tdata[95:64];
            rcx_reg    <= s_tdata[100:96];
            rcy_reg    <= s_tdata[105:101];
            rcz_reg    <= s_tdata[110:106];
        end
    end

    // axis selection for the difference stage
    always_comb
    begin
        case (cmd.diff_axis)
            AX_X:    begin org_sel = cfg.origin_x; pos_sel = pos_reg[0]; end
            AX_Y:    begin org_sel = cfg.origin_y; pos_sel = pos_reg[1]; end
            default: begin org_sel = cfg.origin_z; pos_sel = pos_reg[2]; end
        endcase
    end

    assign diff_hi = $signed(diff_reg[32:16]);
    assign prod    = $signed({pp_hi_reg, 16'd0}) + $signed({18'd0, pp_lo_reg});

    // difference, split product, floor by arithmetic shift
    always_ff @(posedge clk)
    begin
        if (cmd.diff_en)
        begin
            diff_reg <= {pos_sel[31], pos_sel} - {org_sel[31], org_sel};
        end
        if (cmd.pp_en)
        begin
            pp_lo_reg <= diff_reg[15:0] * cfg.inv_cell_len;
            pp_hi_reg <= diff_hi * $signed({1'b0, cfg.inv_cell_len});
        end
        if (cmd.cell_en)
        begin
            case (cmd.cell_axis)
                AX_X:    cell_reg[0] <= prod[57:32];
                AX_Y:    cell_reg[1] <= prod[57:32];
                default: cell_reg[2] <= prod[57:32];
            endcase
        end
    end

    // stamp geometry
    always_comb
    begin
        if (int'(cfg.stamp_size) > STAMP_MAX)
        begin
            size = SW'(STAMP_MAX);
        end
        else
        begin
            size = SW'(cfg.stamp_size);
        end
        half   = size >> 1;
        last_g = size - SW'(1);
    end

    // current stamp cell: offset, distance test, bounds and address
    always_comb
    begin
        ox  = $signed({1'b0, gx_reg}) - $signed({1'b0, half});
        oy  = $signed({1'b0, gy_reg}) - $signed({1'b0, half});
        oz  = $signed({1'b0, gz_reg}) - $signed({1'b0, half});
        sx  = DSQ_W'(ox);
        sy  = DSQ_W'(oy);
        sz  = DSQ_W'(oz);
        dsq = DSQ_W'(sx * sx + sy * sy + sz * sz);
        tx  = cell_reg[0] + CELL_W'(ox);
        ty  = cell_reg[1] + CELL_W'(oy);
        tz  = cell_reg[2] + CELL_W'(oz);
        in_grid = (tx >= 0) && (tx < $signed(CELL_W'(GRID_X))) &&
                  (ty >= 0) && (ty < $signed(CELL_W'(GRID_Y))) &&
                  (tz >= 0) && (tz < $signed(CELL_W'(GRID_Z)));
        hit = in_grid && (dsq < DSQ_W'(cfg.stamp_radius_sq));
        walk_addr = ADDR_W'(tx) + ADDR_W'(ty) * ADDR_W'(GRID_X) +
                    ADDR_W'(tz) * ADDR_W'(GRID_X * GRID_Y);
    end

    // read item address; out-of-grid indices read as zero
    assign read_ok = (32'(rcx_reg) < 32'(GRID_X)) && (32'(rcy_reg) < 32'(GRID_Y)) &&
                     (32'(rcz_reg) < 32'(GRID_Z));
    assign read_addr = ADDR_W'(rcx_reg) + ADDR_W'(rcy_reg) * ADDR_W'(GRID_X) +
                       ADDR_W'(rcz_reg) * ADDR_W'(GRID_X * GRID_Y);
    assign ra        = cmd.walk_step ? walk_addr : read_addr;

    // walk counters, x fastest
    always_ff @(posedge clk)
    begin
        if (cmd.walk_clr)
        begin
            gx_reg <= '0;
            gy_reg <= '0;
            gz_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            if (gx_reg == last_g)
            begin
                gx_reg <= '0;
                if (gy_reg == last_g)
                begin
                    gy_reg <= '0;
                    gz_reg <= gz_reg + SW'(1);
                end
                else
                begin
                    gy_reg <= gy_reg + SW'(1);
                end
            end
            else
            begin
                gx_reg <= gx_reg + SW'(1);
            end
        end
    end

    // write-back stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            hit_reg <= cmd.walk_step && hit;
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    assign sum     = {1'b0, rd_data_reg} + {17'd0, cfg.stamp_weight};
    assign sat_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    // grid memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (hit_reg)
        begin
            mem[wa_reg] <= sat_sum;
        end
        rd_data_reg <= mem[ra];
    end

    // splat tallies and address pipe
    always_ff @(posedge clk)
    begin
        wa_reg    <= walk_addr;
        rd_ok_reg <= read_ok;
        if (cmd.walk_clr)
        begin
            added_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (hit_reg)
        begin
            added_reg <= added_reg + 9'd1;
            sat_reg   <= sat_reg | sum[32];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (act_reg)
            begin
                out_dens_reg  <= rd_ok_reg ? rd_data_reg : 32'd0;
                out_added_reg <= '0;
                out_sat_reg   <= 1'b0;
            end
            else
            begin
                out_dens_reg  <= '0;
                out_added_reg <= added_reg;
                out_sat_reg   <= sat_reg;
            end
        end
    end

    assign m_tdata = {6'd0, out_sat_reg, out_added_reg, out_dens_reg};

    assign sts.is_read   = act_reg;
    assign sts.size_zero = (size == '0);
    assign sts.walk_last = (gx_reg == last_g) && (gy_reg == last_g) && (gz_reg == last_g);
    assign sts.clr_last  = (clr_addr_reg == ADDR_W'(GRID_CELLS - 1));

endmodule
`default_nettype wire

@@ rtl/pdsg_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdsg_ctrl: sequencing state machine
// Clear sweep after reset, cell computation steps, stamp walk, read and
// result hand-off with the output valid flag.
// ----------------------------------------------------------------------------
module pdsg_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire pdsg_pkg::sts_t sts,
    output pdsg_pkg::cmd_t      cmd
);
    import pdsg_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_RD    = 3'd5;
    localparam logic [2:0] ST_RESP  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] calc_reg;
    logic [2:0] calc_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        calc_next      = calc_reg;
        cmd            = '0;
        cmd.capture    = accept;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                calc_next = '0;
                if (accept)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                // three axes overlapped through diff, product and sum stages
                cmd.walk_clr  = (calc_reg == 3'd0);
                cmd.diff_en   = (calc_reg < 3'd3);
                cmd.diff_axis = calc_reg[1:0];
                cmd.pp_en     = (calc_reg >= 3'd1) && (calc_reg <= 3'd3);
                cmd.cell_en   = (calc_reg >= 3'd2);
                cmd.cell_axis = 2'(calc_reg - 3'd2);
                calc_next     = calc_reg + 3'd1;
                // item kind is known in the cycle after capture
                if (calc_reg == 3'd0 && sts.is_read)
                begin
                    state_next = ST_RD;
                end
                else if (calc_reg == 3'd4)
                begin
                    state_next = sts.size_zero ? ST_RESP : ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESP;
            end
            ST_RD:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            calc_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            calc_reg      <= calc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // no item taken during the clear sweep
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("item accepted during grid clear");

    // a result is never loaded over one still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    // last stamp cell is followed by the write-back drain
    a_walk_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && sts.walk_last) |=> (state_reg == ST_DRAIN))
        else $error("walk did not drain");

    // an accepted item leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CALC))
        else $error("accepted item not started");

    // walk only runs in its own state
    a_walk_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (state_reg == ST_WALK))
        else $error("walk step outside walk state");

endmodule
`default_nettype wire

@@ rtl/particle_density_splat_grid.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// particle_density_splat_grid: particle density splatting into a 3D grid
// Splat items add a spherical stamp into a saturating density grid; read
// items return one cell's density.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tdata pos_x,pos_y,pos_z,cell_x,cell_y,cell_z
//                                     tuser action
//  m_*       out  m_tvalid/m_tready   tdata cell_density,cells_added,saturated
//  apb       in   psel/penable        word registers at 4*i, pready high
//
//  A splat runs from accept through cell computation in the split multiplier,
//  then one stamp cell per cycle through the grid memory read-modify-write,
//  a drain step and the result load, and only then can the next item be
//  accepted. An empty stamp skips the walk and the drain; a read item leaves
//  the cell computation at its first step, reads its cell and goes to the
//  result load. After reset the grid is swept to zero, all 32768 cells,
//  before the first item is taken; configuration writes are taken throughout.
//  A waiting result does not block the next accept; the item after it holds
//  in its result load until the waiting result is taken.
// ----------------------------------------------------------------------------
module particle_density_splat_grid
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // slave stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], cell_x[100:96],
    // cell_y[105:101], cell_z[110:106], zero pad [111]
    input  wire logic [pdsg_pkg::S_TDATA_W-1:0] s_tdata,
    // action[0]: 0 splat, 1 read
    input  wire logic                           s_tuser,
    // master stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // cell_density[31:0], cells_added[40:32], saturated[41], zero pad [47:42]
    output logic [pdsg_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pdsg_pkg::APB_AW-1:0]    paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import pdsg_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    pdsg_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdsg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pdsg_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .sts     (sts),
        .m_tdata (m_tdata)
    );

endmodule
`default_nettype wire
